// ===== rtl/core/kss_pkg.sv =====
// Shared constants, types and sequencer codes for the rank selection unit.
// Used by kss_cell, kth_smallest_select_unit and kss_chk.
package kss_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;

  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/kth_smallest_select_unit.sv =====
// Top level of the rank selection unit: a chain of kss_cell instances and
// the sequencer that reads a rank out of it. Depends on kss_pkg and kss_cell.
//
// Usage: values of a data set arrive on the slave stream, one item per cycle,
// tlast marking the last one, which also carries the 0-based rank. Each value
// is put into its place in an ascending chain of 64 cells in the cycle it is
// accepted; values beyond 64 are dropped and reported as overflowed.
// After the last item the chain shifts toward cell 0 once per cycle, rank
// times (not at all on a rank error), and the answer then goes to the output
// register once it is free. Input is not taken during that readout; within a
// data set the rate is one item per cycle. The result is one item on the
// master stream held in an output register; while the receiver stalls, the
// next data set may already stream in, and its result waits in the chain
// until the held one is taken.
// Reset empties the chain and drops any pending result.
module kth_smallest_select_unit
  import kss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] sample, [37:32] wanted_rank
  input  logic                   s_axis_tlast,  // final_item
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] selected
  output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [0] rank_error, [1] overflowed
);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] rank_q, rank_d;
  logic             drop_q, drop_d;
  logic             err_q, err_d;
  logic             ovf_q, ovf_d;
  logic             m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic [OUT_TUSER_W-1:0] m_user_q, m_user_d;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] new_count;
  logic [IDX_W-1:0] in_rank;
  cell_ctrl_t       ctrl;

  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic                     cell_gt  [DEPTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign new_count = full ? count_q : count_q + CNT_W'(1);
  assign in_rank   = s_axis_tdata[DATA_W +: IDX_W];

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state_q == ST_SHIFT);
  assign ctrl.key    = s_axis_tdata[DATA_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_val;
    logic                     prev_gt;
    logic signed [DATA_W-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end

    kss_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (count_q > CNT_W'(i)),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rank_d    = rank_q;
    drop_d    = drop_q;
    err_d     = err_q;
    ovf_d     = ovf_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = new_count;
          drop_d  = drop_q || full;
          if (s_axis_tlast) begin
            rank_d = in_rank;
            err_d  = ({1'b0, in_rank} >= new_count);
            ovf_d  = drop_q || full;
            if (({1'b0, in_rank} >= new_count) || (in_rank == '0)) begin
              state_d = ST_LOAD;
            end else begin
              state_d = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        rank_d = rank_q - IDX_W'(1);
        if (rank_q == IDX_W'(1)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = err_q ? '0 : cell_val[0];
          m_user_d  = {ovf_q, err_q};
          count_d   = '0;
          drop_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      drop_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q   <= rank_d;
    err_q    <= err_d;
    ovf_q    <= ovf_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/core/kss_cell.sv =====
// One cell of the ordered insertion chain: holds one value, takes the new key,
// its left neighbor's value or its right neighbor's value. Depends on kss_pkg.
module kss_cell
  import kss_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occ_i,
  input  logic signed [DATA_W-1:0] prev_val_i,
  input  logic                     prev_gt_i,
  input  logic signed [DATA_W-1:0] next_val_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     gt_o
);

  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] val_d;

  // A free cell counts as larger than any key, so the key lands at the first one.
  assign gt_o = !occ_i || (val_q > ctrl_i.key);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/core/kss_chk.sv =====
// Port-level checks for kth_smallest_select_unit, attached by the bind below.
// Depends on kss_pkg.
module kss_chk
  import kss_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled result changed.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("Rank error with nonzero value.");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("Input taken during readout.");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("Result appeared without a readout.");

endmodule

bind kth_smallest_select_unit kss_chk u_kss_chk (.*);

// ===== sim/kth_smallest_select_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for kth_smallest_select_unit: streams data sets with random gaps and
// stalls and checks each result and its flags against a sorted-queue predictor. Depends on kss_pkg.

module kth_smallest_select_unit_test;
  import kss_pkg::*;

  localparam int unsigned MAX_CYCLES   = 500000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned TARGET_ITEMS = 1800;
  localparam int unsigned PAD_W        = IN_TDATA_W - IDX_W - DATA_W;

  localparam int STYLE_WIDE    = 0;
  localparam int STYLE_NARROW  = 1;
  localparam int STYLE_EXTREME = 2;

  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
    logic [IDX_W-1:0]         rank;
    bit                       hold_for_drain;
  } sample_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] selected;
    logic                     rank_error;
    logic                     overflowed;
  } selection_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  sample_item_t             pending_items[$];
  sample_item_t             current_item;
  selection_t               expected_selections[$];
  logic signed [DATA_W-1:0] ordered_values[$];
  bit                       dropped_value;

  bit input_taken;
  bit result_taken;
  bit sender_quiet;
  bit receiver_quiet;
  int send_gap;
  int stall_left;
  int cycle_count;
  int mismatch_count;
  int accepted_items;
  int queued_items;
  int set_count;
  int rank_error_sets;
  int overflow_sets;

  kth_smallest_select_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what,
             $signed(got), $signed(want));
    mismatch_count++;
  endtask

  // Values are kept in ascending order, so the answer is a plain index.
  task automatic absorb_sample(input sample_item_t item);
    int         pos;
    selection_t sel;
    if (ordered_values.size() >= DEPTH) begin
      dropped_value = 1'b1;
    end else begin
      pos = 0;
      while (pos < ordered_values.size() && ordered_values[pos] <= item.sample) pos++;
      ordered_values.insert(pos, item.sample);
    end
    if (item.last) begin
      if (item.rank < ordered_values.size()) begin
        sel.selected   = ordered_values[item.rank];
        sel.rank_error = 1'b0;
      end else begin
        sel.selected   = '0;
        sel.rank_error = 1'b1;
        rank_error_sets++;
      end
      sel.overflowed = dropped_value;
      if (dropped_value) overflow_sets++;
      set_count++;
      expected_selections.push_back(sel);
      ordered_values.delete();
      dropped_value = 1'b0;
    end
  endtask

  task automatic add_item(input logic signed [DATA_W-1:0] sample, input logic last,
                          input logic [IDX_W-1:0] rank, input bit hold_for_drain);
    sample_item_t item;
    item.sample         = sample;
    item.last           = last;
    item.rank           = rank;
    item.hold_for_drain = hold_for_drain;
    pending_items.push_back(item);
    queued_items++;
  endtask

  function automatic logic signed [DATA_W-1:0] draw_value(input int style);
    case (style)
      STYLE_NARROW: begin
        draw_value = $urandom_range(0, 8) - 4;
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 6))
          0: draw_value = MOST_NEGATIVE;
          1: draw_value = MOST_POSITIVE;
          2: draw_value = MOST_NEGATIVE + 1;
          3: draw_value = MOST_POSITIVE - 1;
          4: draw_value = -1;
          5: draw_value = 0;
          default: draw_value = 1;
        endcase
      end
      default: begin
        draw_value = $urandom;
      end
    endcase
  endfunction

  // Non-final items carry random rank bits, which the block must ignore.
  task automatic add_data_set(input int count, input logic [IDX_W-1:0] rank, input int style,
                              input bit hold_for_drain);
    for (int i = 0; i < count; i++) begin
      add_item(draw_value(style), i == count - 1,
               (i == count - 1) ? rank : IDX_W'($urandom), hold_for_drain && i == 0);
    end
  endtask

  task automatic add_random_set(input bit hold_for_drain);
    int               count;
    int               span;
    int               style;
    logic [IDX_W-1:0] rank;
    case ($urandom_range(0, 99)) inside
      [0:84]:  count = $urandom_range(1, 10);
      [85:92]: count = $urandom_range(11, 40);
      [93:96]: count = DEPTH;
      default: count = $urandom_range(DEPTH + 1, DEPTH + 8);
    endcase
    span = (count > DEPTH) ? DEPTH : count;
    if ($urandom_range(0, 4) == 0) rank = IDX_W'($urandom_range(0, DEPTH - 1));
    else rank = IDX_W'($urandom_range(0, span - 1));
    style = $urandom_range(0, 3);
    add_data_set(count, rank, style, hold_for_drain);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || input_taken) begin
        input_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].hold_for_drain && expected_selections.size() != 0)) begin
          current_item = pending_items.pop_front();
          s_axis_tdata  <= {{PAD_W{1'b0}}, current_item.rank, current_item.sample};
          s_axis_tlast  <= current_item.last;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
          send_gap = sender_quiet ? 0 : $urandom_range(0, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        result_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
        stall_left = receiver_quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    selection_t want;
    if (rst_ni) begin
      cycle_count++;
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_sample(current_item);
        input_taken = 1'b1;
        accepted_items++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_taken = 1'b1;
        if (expected_selections.size() == 0) begin
          report_mismatch("unexpected result, selected", m_axis_tdata, '0);
        end else begin
          want = expected_selections.pop_front();
          if (m_axis_tdata !== want.selected)
            report_mismatch("selected", m_axis_tdata, want.selected);
          if (m_axis_tuser[0] !== want.rank_error)
            report_mismatch("rank_error", 32'(m_axis_tuser[0]), 32'(want.rank_error));
          if (m_axis_tuser[1] !== want.overflowed)
            report_mismatch("overflowed", 32'(m_axis_tuser[1]), 32'(want.overflowed));
        end
      end
      if (cycle_count >= MAX_CYCLES) begin
        $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
                 expected_selections.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    add_item(MOST_NEGATIVE, 1'b1, 6'd0, 1'b0);
    add_item(MOST_POSITIVE, 1'b1, 6'd0, 1'b0);
    add_item(32'sd7, 1'b1, 6'd1, 1'b0);
    add_item(32'sd5, 1'b0, 6'h3F, 1'b0);
    add_item(32'sd5, 1'b0, 6'h2A, 1'b0);
    add_item(-32'sd3, 1'b0, 6'h15, 1'b0);
    add_item(32'sd5, 1'b1, 6'd2, 1'b0);
    add_item(MOST_POSITIVE, 1'b0, 6'd0, 1'b0);
    add_item(MOST_NEGATIVE, 1'b0, 6'd0, 1'b0);
    add_item(32'sd0, 1'b1, 6'd63, 1'b0);
    add_item(-32'sd1, 1'b0, 6'd0, 1'b0);
    add_item(32'sd1, 1'b1, 6'd2, 1'b0);
    add_item(32'sd3, 1'b0, 6'd0, 1'b0);
    add_item(-32'sd1, 1'b1, 6'd1, 1'b0);
    add_item(32'sd0, 1'b0, 6'd0, 1'b1);
    add_item(32'sd0, 1'b0, 6'd0, 1'b0);
    add_item(32'sd0, 1'b1, 6'd0, 1'b0);

    // A full store, then sets that overflow it, in each of which the last item is dropped.
    add_data_set(DEPTH, 6'd63, STYLE_WIDE, 1'b1);
    add_data_set(DEPTH + 2, 6'd0, STYLE_NARROW, 1'b0);
    add_data_set(DEPTH + 8, 6'd63, STYLE_EXTREME, 1'b0);
    while (queued_items < TARGET_ITEMS) add_random_set($urandom_range(0, 24) == 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_selections.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Streamed %0d items in %0d data sets over %0d cycles.", accepted_items, set_count,
             cycle_count);
    $display("Sets with a rank error: %0d, sets that overflowed the store: %0d.",
             rank_error_sets, overflow_sets);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
